>>> rtl/gpioexp_pkg.sv
`default_nettype none
package gpioexp_pkg;

  // Fixed widths of the register interface.
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OP_W     = 2;

  // Default number of existing pins.
  localparam int unsigned PIN_COUNT_DEF = 16;

  // Reset value of the identification register.
  localparam logic [BYTE_W-1:0] CHIP_ID_RST = 8'd35;

  // Register map.
  localparam logic [BYTE_W-1:0] ADDR_IN0  = 8'h00;
  localparam logic [BYTE_W-1:0] ADDR_IN1  = 8'h01;
  localparam logic [BYTE_W-1:0] ADDR_OUT0 = 8'h02;
  localparam logic [BYTE_W-1:0] ADDR_OUT1 = 8'h03;
  localparam logic [BYTE_W-1:0] ADDR_DIR0 = 8'h04;
  localparam logic [BYTE_W-1:0] ADDR_DIR1 = 8'h05;
  localparam logic [BYTE_W-1:0] ADDR_MSK0 = 8'h06;
  localparam logic [BYTE_W-1:0] ADDR_MSK1 = 8'h07;
  localparam logic [BYTE_W-1:0] ADDR_ID   = 8'h10;

  // Item operation codes; the fourth code does nothing.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Replace one 8-bit port of a 16-bit word.
  function automatic logic [FIELD_W-1:0] put_byte(
    input logic [FIELD_W-1:0] word,
    input logic               port,
    input logic [BYTE_W-1:0]  data
  );
    logic [FIELD_W-1:0] res;
    res = word;
    if (port) begin
      res[FIELD_W-1:BYTE_W] = data;
    end else begin
      res[BYTE_W-1:0] = data;
    end
    return res;
  endfunction

  // Select one 8-bit port of a 16-bit word.
  function automatic logic [BYTE_W-1:0] get_byte(
    input logic [FIELD_W-1:0] word,
    input logic               port
  );
    return port ? word[FIELD_W-1:BYTE_W] : word[BYTE_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/gpio_expander_registers_core.sv
// Register side of a 16-pin GPIO expander, two 8-bit ports.
// Throughput: one item per cycle while out_ready is high; the result register
// is the only stage and is refilled in the same cycle that its item is taken.
// Reset (rst_n low, synchronous): pins all input, outputs and masks zero,
// sampled and last seen levels zero, chip_id 35, result register empty.
`default_nettype none
module gpio_expander_registers_core #(
  parameter int unsigned PIN_COUNT = gpioexp_pkg::PIN_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gpioexp_pkg::BYTE_W-1:0]    cfg_data,
  // item input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [gpioexp_pkg::OP_W-1:0]      in_op,
  input  wire logic [gpioexp_pkg::BYTE_W-1:0]    in_reg_addr,
  input  wire logic [gpioexp_pkg::BYTE_W-1:0]    in_write_data,
  input  wire logic [gpioexp_pkg::FIELD_W-1:0]   in_pin_levels,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [gpioexp_pkg::BYTE_W-1:0]         out_read_data,
  output logic [gpioexp_pkg::FIELD_W-1:0]        out_pin_drive,
  output logic [gpioexp_pkg::FIELD_W-1:0]        out_pin_is_input,
  output logic                                   out_irq_active,
  output logic                                   out_bad_address
);
  import gpioexp_pkg::*;

  localparam int unsigned PinW = PIN_COUNT;

  // Pin state, only as wide as the pins that exist.
  logic [PinW-1:0]   sampled_r, sampled_nxt;
  logic [PinW-1:0]   latch_r, latch_nxt;
  logic [PinW-1:0]   dir_r, dir_nxt;
  logic [PinW-1:0]   mask_r, mask_nxt;
  logic [PinW-1:0]   seen_r, seen_nxt;
  logic [BYTE_W-1:0] chip_id_r;

  // Result register.
  logic              out_valid_r;
  logic [BYTE_W-1:0] rdata_r, rdata_nxt;
  logic              irq_r, irq_nxt;
  logic              bad_r, bad_nxt;
  logic [PinW-1:0]   drive_r, is_input_r;

  // Zero-extended views of the state for byte access.
  logic [FIELD_W-1:0] sampled_ext, latch_ext, dir_ext, mask_ext, seen_ext;
  // Full-width word after a byte update, trimmed to the existing pins.
  logic [FIELD_W-1:0] put_word;
  logic               port_sel;
  logic               accept;

  // Refill the result register whenever it is empty or being taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign sampled_ext = FIELD_W'(sampled_r);
  assign latch_ext   = FIELD_W'(latch_r);
  assign dir_ext     = FIELD_W'(dir_r);
  assign mask_ext    = FIELD_W'(mask_r);
  assign seen_ext    = FIELD_W'(seen_r);
  // Bit 0 of the address picks the port within each register pair.
  assign port_sel    = in_reg_addr[0];

  // Decode one item and work out the state after it.
  always_comb begin
    sampled_nxt = sampled_r;
    latch_nxt   = latch_r;
    dir_nxt     = dir_r;
    mask_nxt    = mask_r;
    seen_nxt    = seen_r;
    rdata_nxt   = '0;
    bad_nxt     = 1'b0;
    put_word    = '0;
    unique case (op_t'(in_op))
      OP_TICK: begin
        // Drop levels of pins that do not exist.
        sampled_nxt = in_pin_levels[PinW-1:0];
      end
      OP_READ: begin
        unique case (in_reg_addr) inside
          ADDR_IN0, ADDR_IN1: begin
            // Record the port as last seen by software.
            rdata_nxt = get_byte(sampled_ext, port_sel);
            put_word  = put_byte(seen_ext, port_sel, rdata_nxt);
            seen_nxt  = put_word[PinW-1:0];
          end
          ADDR_OUT0, ADDR_OUT1: rdata_nxt = get_byte(latch_ext, port_sel);
          ADDR_DIR0, ADDR_DIR1: rdata_nxt = get_byte(dir_ext, port_sel);
          ADDR_MSK0, ADDR_MSK1: rdata_nxt = get_byte(mask_ext, port_sel);
          ADDR_ID:              rdata_nxt = chip_id_r;
          default:              bad_nxt   = 1'b1;
        endcase
      end
      OP_WRITE: begin
        unique case (in_reg_addr) inside
          ADDR_OUT0, ADDR_OUT1: begin
            put_word  = put_byte(latch_ext, port_sel, in_write_data);
            latch_nxt = put_word[PinW-1:0];
          end
          ADDR_DIR0, ADDR_DIR1: begin
            put_word = put_byte(dir_ext, port_sel, in_write_data);
            dir_nxt  = put_word[PinW-1:0];
          end
          ADDR_MSK0, ADDR_MSK1: begin
            put_word = put_byte(mask_ext, port_sel, in_write_data);
            mask_nxt = put_word[PinW-1:0];
          end
          // Read-only and unknown addresses: ignore the write.
          default: bad_nxt = 1'b1;
        endcase
      end
      default: begin
        // Unused code: hold all state, plain result.
      end
    endcase
    // Interrupt on any unmasked pin that moved since last seen.
    irq_nxt = |((sampled_nxt ^ seen_nxt) & ~mask_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sampled_r   <= '0;
      latch_r     <= '0;
      dir_r       <= '1;
      mask_r      <= '0;
      seen_r      <= '0;
      chip_id_r   <= CHIP_ID_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        chip_id_r <= cfg_data;
      end
      if (accept) begin
        sampled_r   <= sampled_nxt;
        latch_r     <= latch_nxt;
        dir_r       <= dir_nxt;
        mask_r      <= mask_nxt;
        seen_r      <= seen_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r    <= rdata_nxt;
      irq_r      <= irq_nxt;
      bad_r      <= bad_nxt;
      drive_r    <= latch_nxt;
      is_input_r <= dir_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rdata_r;
  assign out_pin_drive    = FIELD_W'(drive_r);
  assign out_pin_is_input = FIELD_W'(is_input_r);
  assign out_irq_active   = irq_r;
  assign out_bad_address  = bad_r;

  // An accepted item always leaves a result behind.
  a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // A flagged access never returns data.
  a_bad_no_data : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (rdata_r == '0))
    else $error("bad address with nonzero read data");

  // A write to the low output latch shows up in the same item's result.
  a_latch_write : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_WRITE && in_reg_addr == ADDR_OUT0)
      |=> (drive_r[BYTE_W-1:0] == $past(in_write_data)))
    else $error("output latch write not reflected");

  // The interrupt follows the stored state.
  a_irq_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (irq_r == |((sampled_r ^ seen_r) & ~mask_r)))
    else $error("interrupt does not match pin state");

endmodule
`default_nettype wire
